@@ rtl/core/per_byte_modular_exponentiation_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the per-byte modular exponentiation core
// Implication checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PER_BYTE_MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define PER_BYTE_MODULAR_EXPONENTIATION_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define PME_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define PME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PME_ASSERT_SAME(lbl, ante, cons, msg)
`define PME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/pme_pkg.sv @@
// ----------------------------------------------------------------------------
// pme_pkg
// Widths, codes and types shared by the modular exponentiation core.
// ----------------------------------------------------------------------------
package pme_pkg;

    localparam int MOD_BITS  = 31;
    localparam int CHAR_BITS = 8;
    localparam int ACC_BITS  = MOD_BITS + 2;
    localparam int CNT_BITS  = $clog2(MOD_BITS + 1);

    localparam logic [MOD_BITS-1:0] EXP_RESET = MOD_BITS'(1);
    localparam logic [MOD_BITS-1:0] MOD_RESET = {MOD_BITS{1'b1}};

    typedef enum logic [0:0] {
        CFG_EXPONENT = 1'b0,
        CFG_MODULUS  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_STEP,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                go;
        logic [MOD_BITS-1:0] a;
        logic [MOD_BITS-1:0] b;
        logic [MOD_BITS-1:0] n;
    } t_mul_req;

    typedef struct packed {
        logic                done;
        logic [MOD_BITS-1:0] prod;
    } t_mul_rsp;

endpackage

@@ rtl/core/per_byte_modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// per_byte_modular_exponentiation_core
// Raises each request byte to the configured exponent modulo the modulus.
//
//  Channel  | Ports                                   | Flow
//  ---------+-----------------------------------------+----------------------
//  request  | start, busy, i_char_code                | taken when start & !busy
//  result   | o_done, o_cipher_word                   | one-cycle strobe
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data         | write on i_cfg_we
//
// Right-to-left square-and-multiply on one bit-serial modular multiplier:
// the byte is first reduced mod n, then every exponent bit up to the top set
// bit costs one squaring, and every set bit one multiply before it.
// A zero modulus skips the multiplier and goes straight to the done state.
// Reset is synchronous and active low; the result cannot be stalled.
// ----------------------------------------------------------------------------
`include "per_byte_modular_exponentiation_core_macros.svh"

module per_byte_modular_exponentiation_core
    import pme_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CHAR_BITS-1:0] i_char_code,
    output logic                 o_done,
    output logic [MOD_BITS-1:0]  o_cipher_word,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [MOD_BITS-1:0]  i_cfg_data
);

    t_state              r_state, n_state;
    logic [MOD_BITS-1:0] r_exponent, r_modulus;
    logic [MOD_BITS-1:0] r_exp, n_exp;
    logic [MOD_BITS-1:0] r_base, n_base;
    logic [MOD_BITS-1:0] r_res, n_res;
    logic [MOD_BITS-1:0] r_word, n_word;
    logic                r_done, n_done;
    logic [MOD_BITS-1:0] w_one;
    t_mul_req            w_req;
    t_mul_rsp            w_rsp;

    assign w_one = (r_modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXP_RESET;
            r_modulus  <= MOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp  <= n_exp;
        r_base <= n_base;
        r_res  <= n_res;
        r_word <= n_word;
    end

    always_comb begin
        n_state = r_state;
        n_exp   = r_exp;
        n_base  = r_base;
        n_res   = r_res;
        n_word  = r_word;
        n_done  = 1'b0;
        w_req.go = 1'b0;
        w_req.a  = r_res;
        w_req.b  = r_base;
        w_req.n  = r_modulus;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_exp = r_exponent;
                    if (r_modulus == '0) begin
                        n_res   = '0;
                        n_state = ST_DONE;
                    end else begin
                        // The byte is reduced by multiplying it with 1 mod n.
                        w_req.go = 1'b1;
                        w_req.a  = w_one;
                        w_req.b  = MOD_BITS'(i_char_code);
                        n_state  = ST_BASE;
                    end
                end
            end
            ST_BASE: begin
                if (w_rsp.done) begin
                    n_base  = w_rsp.prod;
                    n_res   = w_one;
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (r_exp == '0) begin
                    n_state = ST_DONE;
                end else if (r_exp[0]) begin
                    w_req.go = 1'b1;
                    n_state  = ST_MUL;
                end else begin
                    w_req.go = 1'b1;
                    w_req.a  = r_base;
                    n_state  = ST_SQR;
                end
            end
            ST_MUL: begin
                if (w_rsp.done) begin
                    n_res    = w_rsp.prod;
                    w_req.go = 1'b1;
                    w_req.a  = r_base;
                    n_state  = ST_SQR;
                end
            end
            ST_SQR: begin
                if (w_rsp.done) begin
                    n_base  = w_rsp.prod;
                    n_exp   = {1'b0, r_exp[MOD_BITS-1:1]};
                    n_state = ST_STEP;
                end
            end
            ST_DONE: begin
                n_done  = 1'b1;
                n_word  = r_res;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    pme_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_cipher_word = r_word;

    `PME_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but core not busy")
    `PME_ASSERT_NEXT(a_exp_spent, r_state == ST_STEP && r_exp == '0, r_state == ST_DONE,
        "exponent spent but no result scheduled")
    `PME_ASSERT_SAME(a_done_idle, o_done, !busy, "result strobe while still working")

endmodule

@@ rtl/core/pme_mulmod.sv @@
// ----------------------------------------------------------------------------
// pme_mulmod
// Bit-serial modular multiplier: a * b mod n, one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
`include "per_byte_modular_exponentiation_core_macros.svh"

module pme_mulmod
    import pme_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS-1:0] r_b;
    logic [MOD_BITS-1:0] r_a;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [ACC_BITS-1:0] w_two, w_sum, w_n1, w_n2;

    // The accumulator stays below n, so 2r + a is below 3n and the right
    // remainder is picked from the candidates computed side by side.
    always_comb begin
        w_two = {1'b0, r_acc, 1'b0};
        w_n1  = {2'b00, i_req.n};
        w_n2  = {1'b0, i_req.n, 1'b0};
        w_sum = w_two + {2'b00, r_a};
        if (r_b[MOD_BITS-1]) begin
            if (w_sum >= w_n2) begin
                n_acc = MOD_BITS'(w_sum - w_n2);
            end else if (w_sum >= w_n1) begin
                n_acc = MOD_BITS'(w_sum - w_n1);
            end else begin
                n_acc = MOD_BITS'(w_sum);
            end
        end else begin
            if (w_two >= w_n1) begin
                n_acc = MOD_BITS'(w_two - w_n1);
            end else begin
                n_acc = MOD_BITS'(w_two);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(MOD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[MOD_BITS-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    `PME_ASSERT_SAME(a_go_when_free, i_req.go, !r_busy, "multiply started while busy")
    `PME_ASSERT_NEXT(a_last_bit_done, r_busy && r_cnt == CNT_BITS'(1), r_done && !r_busy,
        "multiply did not finish after its last bit")
    `PME_ASSERT_SAME(a_prod_reduced, r_done && i_req.n != '0, r_acc < i_req.n,
        "product not reduced below the modulus")

endmodule
